// ===== rtl/core/wfsq_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wfsq_pkg: shared types and constants of the weighted fair scheduler queue
// Transaction structs, class weights, sequencer states and entry ordering.
// ============================================================================
package wfsq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_THREADS_DEF = 64;

   localparam int RT_W     = 24;  // accumulated runtime / service time
   localparam int KEY_W    = 48;  // virtual runtime key, 16 fraction bits
   localparam int FRAC_W   = 16;
   localparam int KEY_SH   = 26;  // *1024 and 16 fraction bits
   localparam int WGT_W    = 17;  // largest class weight
   localparam int WSUM_W   = 22;
   localparam int ORDER_W  = 32;
   localparam int DVD_W    = RT_W + KEY_SH;
   localparam int SHARE_W  = WGT_W + 6;  // 48 * weight
   localparam int VRT_W    = 31;
   localparam int SLICE_W  = 10;
   localparam int QCNT_W   = 6;

   localparam logic [SLICE_W-1:0] MIN_GRAN_RESET = SLICE_W'(3);
   localparam logic MODE_PICK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic            mode;
      logic [5:0]      thread_id;
      logic [1:0]      priority_class;
      logic [RT_W-1:0] run_ticks;
   } req_type;

   typedef struct packed {
      logic                picked_valid;
      logic [5:0]          picked_thread;
      logic [VRT_W-1:0]    virtual_runtime;
      logic [SLICE_W-1:0]  slice_ticks;
      logic [QCNT_W-1:0]   queue_count;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [5:0]         thread;
      logic [1:0]         cls;
      logic [ORDER_W-1:0] order;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_TLOAD,
      ST_KDIV,
      ST_SCAN,
      ST_SCANEND,
      ST_LAST,
      ST_MOVE,
      ST_SDIV,
      ST_FINISH
   } state_type;

   function automatic logic [WGT_W-1:0] class_weight(input logic [1:0] cls);
      logic [WGT_W-1:0] w;
      unique case (cls)
         2'd0:    w = WGT_W'(88761);
         2'd1:    w = WGT_W'(29154);
         2'd2:    w = WGT_W'(1024);
         default: w = WGT_W'(15);
      endcase
      return w;
   endfunction

   // Smaller key first; on a tie the older stamp, compared modulo 2^32.
   function automatic logic goes_first(input entry_type a, input entry_type b);
      logic [ORDER_W-1:0] diff;
      diff = a.order - b.order;
      if (a.key != b.key) begin
         return a.key < b.key;
      end
      return diff[ORDER_W-1];
   endfunction

endpackage

// ===== rtl/core/weighted_fair_scheduler_queue_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// weighted_fair_scheduler_queue_core: fair-share ready queue
// Queues threads under a weighted virtual runtime key and picks the smallest.
// ============================================================================
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------
//  req     | in        | req_valid/req_stall | wfsq_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | wfsq_pkg::rsp_type
//  csr     | in        | csr_we              | csr_wdata (min granularity)
//
//  An add goes from acceptance to a valid rsp through the thread id reduction
//  steps, the table load, the divider steps with its registered done, and the
//  finish state. A pick reads the entry memory once per queued entry for the
//  minimum search, settles the winner (SCANEND), reads the last entry (LAST)
//  and moves it into the hole (MOVE), then runs the divider and finish. The
//  sequencer returns to idle before the next req is taken; a stalled rsp holds
//  the finish state. After reset a clearing pass zeroes every entry of the
//  per-thread table; req_stall stays high during it. One transaction is
//  worked at a time; a finished result waits in the rsp register while the
//  next req is taken. A full add or an empty pick goes straight to finish.
//
module weighted_fair_scheduler_queue_core #(
   parameter int QUEUE_DEPTH = wfsq_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_THREADS = wfsq_pkg::MAX_THREADS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wfsq_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wfsq_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_we,
   input  logic [wfsq_pkg::SLICE_W-1:0]      csr_wdata
);

   localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int TW    = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int RW    = (TW + 1 > 6) ? TW + 1 : 6;
   localparam int DSR_W = CW + wfsq_pkg::WSUM_W;
   localparam int RT_W  = wfsq_pkg::RT_W;
   localparam int DVD_W = wfsq_pkg::DVD_W;

   // --- state -----------------------------------------------------------
   wfsq_pkg::state_type  state_ff, state_in;
   wfsq_pkg::req_type    req_ff, req_in;
   logic [RW-1:0]        tidx_ff, tidx_in;
   logic [TW-1:0]        clr_ff, clr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [wfsq_pkg::ORDER_W-1:0] seq_ff, seq_in;
   logic [wfsq_pkg::WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [wfsq_pkg::SLICE_W-1:0] mg_ff;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [QW-1:0]        rd_idx_ff, rd_idx_in;
   wfsq_pkg::entry_type  best_ff, best_in;
   logic [QW-1:0]        best_idx_ff, best_idx_in;
   logic                 dz_ff, dz_in;
   wfsq_pkg::rsp_type    res_ff, res_in;
   wfsq_pkg::rsp_type    rsp_ff;
   logic                 rsp_valid_ff;
   logic                 load_rsp;

   // --- per-thread table {accumulated, last service} -------------------
   logic [2*RT_W-1:0]    thr_mem [MAX_THREADS];
   logic [2*RT_W-1:0]    thr_rdata_ff;
   logic                 thr_we;
   logic [TW-1:0]        thr_waddr;
   logic [2*RT_W-1:0]    thr_wdata;

   // --- queue entries ---------------------------------------------------
   wfsq_pkg::entry_type  ent_mem [QUEUE_DEPTH];
   wfsq_pkg::entry_type  ent_rdata_ff;
   logic                 ent_we;
   logic [QW-1:0]        ent_waddr, ent_raddr;
   wfsq_pkg::entry_type  ent_wdata;

   // --- shared divider --------------------------------------------------
   logic                 div_start;
   logic [DVD_W-1:0]     div_dividend, div_quot;
   logic [DSR_W-1:0]     div_divisor;
   wfsq_pkg::div_status_type div_stat;

   wfsq_div #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (DSR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // --- datapath helpers ------------------------------------------------
   logic [RT_W-1:0]      thr_acc, thr_last;
   logic signed [RT_W+1:0] acc_raw;
   logic [RT_W-1:0]      acc_clamp;
   logic [wfsq_pkg::WGT_W-1:0] req_w, best_w;
   logic [wfsq_pkg::SHARE_W-1:0] share_num;
   logic [DSR_W-1:0]     denom;
   logic [CW-1:0]        count_m1;
   logic [DVD_W-1:0]     share;

   assign thr_acc   = thr_rdata_ff[2*RT_W-1:RT_W];
   assign thr_last  = thr_rdata_ff[RT_W-1:0];
   assign acc_raw   = $signed({2'b00, thr_acc}) + $signed({2'b00, req_ff.run_ticks})
                      - $signed({2'b00, thr_last});
   assign req_w     = wfsq_pkg::class_weight(req_ff.priority_class);
   assign best_w    = wfsq_pkg::class_weight(best_ff.cls);
   // 48 * w as two shifted terms
   assign share_num = (wfsq_pkg::SHARE_W'(best_w) << 5) + (wfsq_pkg::SHARE_W'(best_w) << 4);
   assign denom     = DSR_W'(count_ff) * DSR_W'(wsum_ff);
   assign count_m1  = count_ff - CW'(1);
   assign share     = dz_ff ? '0 : div_quot;

   always_comb begin
      // clamp the signed runtime growth to 0 .. 2^24-1
      if (acc_raw < 0) begin
         acc_clamp = '0;
      end else if (acc_raw > $signed({2'b00, {RT_W{1'b1}}})) begin
         acc_clamp = '1;
      end else begin
         acc_clamp = acc_raw[RT_W-1:0];
      end
   end

   // --- sequencer -------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      tidx_in      = tidx_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      seq_in       = seq_ff;
      wsum_in      = wsum_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_ff[QW-1:0];
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      dz_in        = dz_ff;
      res_in       = res_ff;
      load_rsp     = 1'b0;
      thr_we       = 1'b0;
      thr_waddr    = clr_ff;
      thr_wdata    = '0;
      ent_we       = 1'b0;
      ent_waddr    = count_ff[QW-1:0];
      ent_wdata    = ent_rdata_ff;
      ent_raddr    = scan_ff[QW-1:0];
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      // fold the entry read last cycle into the running minimum
      if (rd_vld_ff && ((rd_idx_ff == '0) || wfsq_pkg::goes_first(ent_rdata_ff, best_ff))) begin
         best_in     = ent_rdata_ff;
         best_idx_in = rd_idx_ff;
      end

      unique case (state_ff)
         wfsq_pkg::ST_CLEAR: begin
            thr_we = 1'b1;
            if (clr_ff == TW'(MAX_THREADS - 1)) begin
               state_in = wfsq_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + TW'(1);
            end
         end
         wfsq_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_payload;
               tidx_in = RW'(req_payload.thread_id);
               scan_in = '0;
               res_in  = '0;
               res_in.queue_count = wfsq_pkg::QCNT_W'(count_ff);
               if (req_payload.mode == wfsq_pkg::MODE_PICK) begin
                  if (count_ff == '0) begin
                     res_in.status = wfsq_pkg::STATUS_EMPTY;
                     state_in      = wfsq_pkg::ST_FINISH;
                  end else begin
                     state_in = wfsq_pkg::ST_SCAN;
                  end
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  res_in.status = wfsq_pkg::STATUS_FULL;
                  state_in      = wfsq_pkg::ST_FINISH;
               end else begin
                  state_in = wfsq_pkg::ST_MOD;
               end
            end
         end
         wfsq_pkg::ST_MOD: begin
            // reduce the thread id modulo the table size
            if (tidx_ff >= RW'(MAX_THREADS)) begin
               tidx_in = tidx_ff - RW'(MAX_THREADS);
            end else begin
               state_in = wfsq_pkg::ST_TLOAD;
            end
         end
         wfsq_pkg::ST_TLOAD: begin
            thr_we       = 1'b1;
            thr_waddr    = tidx_ff[TW-1:0];
            thr_wdata    = {acc_clamp, req_ff.run_ticks};
            div_start    = 1'b1;
            div_dividend = {acc_clamp, {wfsq_pkg::KEY_SH{1'b0}}};
            div_divisor  = DSR_W'(req_w);
            state_in     = wfsq_pkg::ST_KDIV;
         end
         wfsq_pkg::ST_KDIV: begin
            if (div_stat.done) begin
               ent_we          = 1'b1;
               ent_wdata.key   = div_quot[wfsq_pkg::KEY_W-1:0];
               ent_wdata.thread = req_ff.thread_id;
               ent_wdata.cls   = req_ff.priority_class;
               ent_wdata.order = seq_ff;
               seq_in          = seq_ff + wfsq_pkg::ORDER_W'(1);
               count_in        = count_ff + CW'(1);
               wsum_in         = wsum_ff + wfsq_pkg::WSUM_W'(req_w);
               res_in.queue_count = wfsq_pkg::QCNT_W'(count_ff + CW'(1));
               state_in        = wfsq_pkg::ST_FINISH;
            end
         end
         wfsq_pkg::ST_SCAN: begin
            rd_vld_in = 1'b1;
            scan_in   = scan_ff + CW'(1);
            if (scan_ff == count_m1) begin
               state_in = wfsq_pkg::ST_SCANEND;
            end
         end
         wfsq_pkg::ST_SCANEND: begin
            state_in = wfsq_pkg::ST_LAST;
         end
         wfsq_pkg::ST_LAST: begin
            ent_raddr = count_m1[QW-1:0];
            state_in  = wfsq_pkg::ST_MOVE;
         end
         wfsq_pkg::ST_MOVE: begin
            // move the last entry into the hole left by the winner
            ent_we       = 1'b1;
            ent_waddr    = best_idx_ff;
            div_start    = 1'b1;
            div_dividend = DVD_W'(share_num);
            div_divisor  = denom;
            dz_in        = (denom == '0);
            state_in     = wfsq_pkg::ST_SDIV;
         end
         wfsq_pkg::ST_SDIV: begin
            if (div_stat.done) begin
               res_in.picked_valid    = 1'b1;
               res_in.picked_thread   = best_ff.thread;
               res_in.virtual_runtime =
                  best_ff.key[wfsq_pkg::FRAC_W +: wfsq_pkg::VRT_W];
               if (share < DVD_W'(mg_ff)) begin
                  res_in.slice_ticks = mg_ff;
               end else begin
                  res_in.slice_ticks = share[wfsq_pkg::SLICE_W-1:0];
               end
               res_in.queue_count = wfsq_pkg::QCNT_W'(count_m1);
               res_in.status      = wfsq_pkg::STATUS_OK;
               count_in = count_m1;
               wsum_in  = wsum_ff - wfsq_pkg::WSUM_W'(best_w);
               state_in = wfsq_pkg::ST_FINISH;
            end
         end
         wfsq_pkg::ST_FINISH: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = wfsq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfsq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfsq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         seq_ff       <= '0;
         wsum_ff      <= '0;
         mg_ff        <= wfsq_pkg::MIN_GRAN_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         count_ff  <= count_in;
         seq_ff    <= seq_in;
         wsum_ff   <= wsum_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_we) begin
            mg_ff <= csr_wdata;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      tidx_ff     <= tidx_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      dz_ff       <= dz_in;
      res_ff      <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (thr_we) begin
         thr_mem[thr_waddr] <= thr_wdata;
      end
      thr_rdata_ff <= thr_mem[tidx_ff[TW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   assign req_stall   = (state_ff != wfsq_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/wfsq_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wfsq_div: shared restoring divider
// One quotient bit per cycle; done pulses when the quotient is final.
// ============================================================================
module wfsq_div #(
   parameter int DIVIDEND_W = wfsq_pkg::DVD_W,
   parameter int DIVISOR_W  = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DIVIDEND_W-1:0]  dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output logic [DIVIDEND_W-1:0]  quotient,
   output wfsq_pkg::div_status_type stat
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [DIVISOR_W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== rtl/core/wfsq_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wfsq_checker: port-level checks for the fair scheduler queue
// Watches the req and rsp channels of the top level; attached by bind.
// ============================================================================
module wfsq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wfsq_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp changed");

   // a flagged result never carries a thread or a slice
   a_flag_no_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != wfsq_pkg::STATUS_OK) |->
         !rsp_payload.picked_valid && (rsp_payload.slice_ticks == '0))
      else $error("flagged rsp carries a pick");

   // the clearing pass holds off requests right after reset
   a_reset_stall: assert property (@(posedge clock)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("not stalled after reset");

   // an empty-queue flag reports no queued entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == wfsq_pkg::STATUS_EMPTY) |->
         (rsp_payload.queue_count == '0))
      else $error("empty flag with entries queued");

endmodule

bind weighted_fair_scheduler_queue_core wfsq_checker u_wfsq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== bench/tb_weighted_fair_scheduler_queue_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_weighted_fair_scheduler_queue_core: self-checking bench of the ready queue
// Drives add and pick transactions with random bursts and gaps, stalls the
// result side on its own pattern, and checks every result field by field
// against a behavioral queue model kept in the bench.
// ============================================================================
module tb_weighted_fair_scheduler_queue_core;

   localparam int QDEPTH   = 32;
   localparam int NTHREAD  = 64;
   localparam int WATCHDOG = 20000;
   localparam int N_RANDOM = 672;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   wfsq_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wfsq_pkg::rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [wfsq_pkg::SLICE_W-1:0] csr_wdata = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   weighted_fair_scheduler_queue_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Queue model: private copy of the ready queue and per-thread tables
   // ---------------------------------------------------------------------
   logic [47:0] q_key   [QDEPTH];
   logic [5:0]  q_tid   [QDEPTH];
   logic [1:0]  q_cls   [QDEPTH];
   logic [31:0] q_stamp [QDEPTH];
   int unsigned q_len;
   logic [31:0] next_stamp;
   logic [21:0] total_weight;
   logic [23:0] thread_runtime [NTHREAD];
   logic [23:0] thread_last    [NTHREAD];
   logic [wfsq_pkg::SLICE_W-1:0] granularity;

   wfsq_pkg::rsp_type pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit drive_done = 1'b0;

   function automatic logic [16:0] weight_of(logic [1:0] c);
      case (c)
         2'd0:    return 17'd88761;
         2'd1:    return 17'd29154;
         2'd2:    return 17'd1024;
         default: return 17'd15;
      endcase
   endfunction

   task automatic reset_queue_model();
      q_len = 0;
      next_stamp = '0;
      total_weight = '0;
      granularity = wfsq_pkg::MIN_GRAN_RESET;
      for (int i = 0; i < NTHREAD; i++) begin
         thread_runtime[i] = '0;
         thread_last[i] = '0;
      end
   endtask

   // Advance the model by one transaction and return the expected result.
   function automatic wfsq_pkg::rsp_type schedule_step(wfsq_pkg::req_type r);
      wfsq_pkg::rsp_type o;
      longint acc;
      logic [16:0] w;
      logic [31:0] d;
      int best;
      longint unsigned share, denom;
      o = '0;
      o.status = wfsq_pkg::STATUS_OK;
      if (r.mode != wfsq_pkg::MODE_PICK) begin
         if (q_len >= QDEPTH) begin
            o.status = wfsq_pkg::STATUS_FULL;
         end else begin
            acc = longint'(thread_runtime[r.thread_id]) + longint'(r.run_ticks)
                  - longint'(thread_last[r.thread_id]);
            if (acc < 0) acc = 0;
            if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
            w = weight_of(r.priority_class);
            thread_runtime[r.thread_id] = acc[23:0];
            thread_last[r.thread_id] = r.run_ticks;
            q_key[q_len] = 48'((acc << 26) / longint'(w));
            q_tid[q_len] = r.thread_id;
            q_cls[q_len] = r.priority_class;
            q_stamp[q_len] = next_stamp;
            next_stamp++;
            q_len++;
            total_weight = total_weight + 22'(w);
         end
      end else if (q_len == 0) begin
         o.status = wfsq_pkg::STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < q_len; i++) begin
            d = q_stamp[i] - q_stamp[best];
            if (q_key[i] < q_key[best] || (q_key[i] == q_key[best] && d[31]))
               best = i;
         end
         w = weight_of(q_cls[best]);
         denom = longint'(q_len) * longint'(total_weight);
         share = (denom == 0) ? 0 : (48 * longint'(w)) / denom;
         o.slice_ticks = (share < granularity) ? granularity
                                               : wfsq_pkg::SLICE_W'(share);
         o.picked_valid = 1'b1;
         o.picked_thread = q_tid[best];
         o.virtual_runtime = 31'(q_key[best] >> 16);
         total_weight = total_weight - 22'(w);
         q_len--;
         q_key[best] = q_key[q_len];
         q_tid[best] = q_tid[q_len];
         q_cls[best] = q_cls[q_len];
         q_stamp[best] = q_stamp[q_len];
      end
      o.queue_count = wfsq_pkg::QCNT_W'(q_len);
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Sender: one transaction, held until accepted, after an optional burst-start gap
   // ---------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_item(wfsq_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap != 0) begin
            // drop valid so the last transaction is not taken twice
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(schedule_step(r));
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_granularity(logic [wfsq_pkg::SLICE_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      granularity = v;
   endtask

   function automatic wfsq_pkg::req_type make_req(bit m, int tid, int cls, int st);
      wfsq_pkg::req_type r;
      r.mode = m;
      r.thread_id = 6'(tid);
      r.priority_class = 2'(cls);
      r.run_ticks = 24'(st);
      return r;
   endfunction

   // Directed table: expected status and count are given for the rows where
   // they are plain; every row is also checked against the queue model.
   typedef struct {
      wfsq_pkg::req_type    r;
      bit                   known;
      wfsq_pkg::status_type st;
      int                   cnt;
   } directed_row_type;

   directed_row_type dir_rows[$];

   function automatic wfsq_pkg::req_type random_req(int pick_pct, int tid_max);
      wfsq_pkg::req_type r;
      r.mode = ($urandom_range(0, 99) < pick_pct);
      r.thread_id = 6'($urandom_range(0, tid_max));
      r.priority_class = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0:       r.run_ticks = 24'hFFFFFF;
         1:       r.run_ticks = '0;
         2:       r.run_ticks = 24'($urandom);
         default: r.run_ticks = thread_last[r.thread_id]
                                + 24'($urandom_range(0, 5000));
      endcase
      return r;
   endfunction

   initial begin
      reset_queue_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Pick on empty, extremes, every class, a tie, then drain to empty.
      dir_rows.push_back('{make_req(1, 0, 0, 0), 1, wfsq_pkg::STATUS_EMPTY, 0});
      dir_rows.push_back('{make_req(0, 63, 3, 24'hFFFFFF), 1, wfsq_pkg::STATUS_OK, 1});
      dir_rows.push_back('{make_req(0, 0, 0, 0), 1, wfsq_pkg::STATUS_OK, 2});
      dir_rows.push_back('{make_req(0, 5, 1, 1000), 1, wfsq_pkg::STATUS_OK, 3});
      // time goes backwards
      dir_rows.push_back('{make_req(0, 5, 2, 10), 1, wfsq_pkg::STATUS_OK, 4});
      // tie with earlier
      dir_rows.push_back('{make_req(0, 0, 0, 0), 1, wfsq_pkg::STATUS_OK, 5});
      for (int i = 0; i < 5; i++)
         dir_rows.push_back('{make_req(1, 0, 0, 0), 1, wfsq_pkg::STATUS_OK, 4 - i});
      dir_rows.push_back('{make_req(1, 0, 0, 0), 1, wfsq_pkg::STATUS_EMPTY, 0});
      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].r);
         if (dir_rows[i].known && (pending_rsp[$].status != dir_rows[i].st ||
                                   pending_rsp[$].queue_count != dir_rows[i].cnt))
            report_mismatch("directed row", i, 0);
      end
      // Fill the queue past its depth, then drain one more than queued.
      for (int i = 0; i < QDEPTH + 2; i++)
         send_item(make_req(0, i, i % 4, i * 37));
      if (pending_rsp[$].status != wfsq_pkg::STATUS_FULL) report_mismatch("full drop", 0, 1);
      for (int i = 0; i < QDEPTH + 1; i++)
         send_item(make_req(1, 0, 0, 0));

      // Random phases over several granularity settings, extremes included.
      for (int ph = 0; ph < 4; ph++) begin
         logic [wfsq_pkg::SLICE_W-1:0] g;
         go_quiet();
         case (ph)
            0: g = 10'd1;
            1: g = 10'd1023;
            2: g = 10'($urandom_range(1, 1023));
            default: g = 10'd3;
         endcase
         write_granularity(g);
         if (ph == 2) hold_off = 1'b1;
         for (int n = 0; n < N_RANDOM / 4; n++)
            send_item(random_req((ph == 1) ? 30 : 50, (ph == 0) ? 7 : 63));
         hold_off = 1'b0;
      end
      req_valid <= 1'b0;
      drive_done = 1'b1;
   end

   // Receiver: stall on its own pattern; one long hold-off when asked.
   initial begin
      bit held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (800) @(posedge clock);
         end
         case ($urandom_range(0, 7))
            0, 1:    rsp_stall <= 1'b1;
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Checker and watchdog
   always @(posedge clock) begin
      wfsq_pkg::rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("result with none expected", 0, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_payload.picked_valid != want.picked_valid)
                  report_mismatch("picked_valid", rsp_payload.picked_valid, want.picked_valid);
               if (rsp_payload.picked_thread != want.picked_thread)
                  report_mismatch("picked_thread", rsp_payload.picked_thread,
                                  want.picked_thread);
               if (rsp_payload.virtual_runtime != want.virtual_runtime)
                  report_mismatch("virtual_runtime", rsp_payload.virtual_runtime,
                                  want.virtual_runtime);
               if (rsp_payload.slice_ticks != want.slice_ticks)
                  report_mismatch("slice_ticks", rsp_payload.slice_ticks, want.slice_ticks);
               if (rsp_payload.queue_count != want.queue_count)
                  report_mismatch("queue_count", rsp_payload.queue_count, want.queue_count);
               if (rsp_payload.status != want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WATCHDOG) begin
            $display("tb_weighted_fair_scheduler_queue_core: FAIL");
            $finish;
         end
         if (drive_done && pending_rsp.size() == 0) begin
            repeat (200) @(posedge clock);
            if (errors == 0 && pending_rsp.size() == 0)
               $display("tb_weighted_fair_scheduler_queue_core: PASS");
            else
               $display("tb_weighted_fair_scheduler_queue_core: FAIL");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
rtl/core/wfsq_pkg.sv
rtl/core/wfsq_div.sv
rtl/core/weighted_fair_scheduler_queue_core.sv
rtl/core/wfsq_checker.sv
bench/tb_weighted_fair_scheduler_queue_core.sv
